// ===== design/pgl_pkg.sv =====
// Shared types, grid constants and tables for the pad grid latch controller.
`default_nettype none

package pgl_pkg;

    localparam int GRID_WIDTH  = 8;
    localparam int GRID_HEIGHT = 8;
    localparam int FLASH_ROWS  = 2;

    localparam int PAD_COUNT   = GRID_WIDTH * GRID_HEIGHT;
    localparam int PAD_IDX_W   = 6;
    localparam int COL_W       = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
    localparam int ROW_W       = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int NOTE_COUNT  = 128;

    // momentary border, capped at the pad count
    localparam int FLASH_BORDER =
        (FLASH_ROWS * GRID_WIDTH > PAD_COUNT) ? PAD_COUNT : FLASH_ROWS * GRID_WIDTH;

    localparam logic [7:0] PAD_END_B    = 8'(PAD_COUNT);
    localparam logic [7:0] FLASH_END_B  = 8'(FLASH_BORDER);
    localparam logic [7:0] STOP_END_B   = 8'((GRID_HEIGHT + 1) * GRID_WIDTH);

    localparam logic [6:0] TOGGLE_NOTE  = 7'd82;

    localparam logic [1:0] CMD_NOTE_OFF = 2'd0;
    localparam logic [1:0] CMD_NOTE_ON  = 2'd1;

    typedef enum logic [1:0] {
        OP_PRESS,
        OP_RELEASE,
        OP_TOGGLE
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [6:0] note;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_COLUMN,
        BK_FINAL
    } t_back_state;

    typedef logic [COL_W-1:0] t_col_tab [NOTE_COUNT];

    // column of every note number, built by counting
    function automatic t_col_tab build_col_tab();
        t_col_tab tab;
        int       col;
        col = 0;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            tab[i] = COL_W'(col);
            col = (col == GRID_WIDTH - 1) ? 0 : col + 1;
        end
        return tab;
    endfunction

    localparam t_col_tab COL_TAB = build_col_tab();

endpackage

`default_nettype wire

// ===== design/pgl_front.sv =====
// Front end: listen channel register, event filter and classification into ops.
`default_nettype none

module pgl_front import pgl_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [3:0] i_cfg_data,
    input  wire logic       start,
    input  wire logic       i_busy,
    input  wire logic [1:0] i_cmd,
    input  wire logic [3:0] i_channel,
    input  wire logic [6:0] i_note,
    input  wire logic [6:0] i_velocity,
    output logic            o_push,
    output t_op             o_op
);

    logic [3:0] r_listen_channel;
    logic       keep;
    logic       is_on;
    logic [7:0] note_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_channel <= 4'd0;
        end else if (i_cfg_valid) begin
            r_listen_channel <= i_cfg_data;
        end
    end

    assign note_b = {1'b0, i_note};
    assign is_on  = (i_cmd == CMD_NOTE_ON) && (i_velocity != 7'd0);

    always_comb begin
        keep        = 1'b0;
        o_op.kind   = OP_PRESS;
        o_op.note   = i_note;
        if (((i_cmd == CMD_NOTE_OFF) || (i_cmd == CMD_NOTE_ON))
                && (i_channel == r_listen_channel)) begin
            if (i_note == TOGGLE_NOTE) begin
                keep      = is_on;
                o_op.kind = OP_TOGGLE;
            end else if (is_on) begin
                keep      = note_b < STOP_END_B;
                o_op.kind = OP_PRESS;
            end else begin
                // releases beyond the grid can never hit a momentary pad
                keep      = note_b < PAD_END_B;
                o_op.kind = OP_RELEASE;
            end
        end
    end

    assign o_push = start && !i_busy && keep;

endmodule

`default_nettype wire

// ===== design/pgl_queue.sv =====
// Two-entry op queue between front end and back end.
`default_nettype none

module pgl_queue import pgl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_op       i_op,
    input  wire logic i_pop,
    output t_op       o_op,
    output t_q_status o_status
);

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_op           = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/pgl_back.sv =====
// Back end: pad state, flash mode, column and sweep sequencer, LED message register.
`default_nettype none

module pgl_back import pgl_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  t_q_status                 i_q_status,
    input  t_op                       i_op,
    output logic                      o_pop,
    output logic                      o_strobe,
    output logic [PAD_IDX_W-1:0]      o_pad_index,
    output logic                      o_pad_lit,
    output logic                      o_flash_update,
    output logic                      o_flash_lit,
    output logic                      o_last
);

    t_back_state          r_state, n_state;
    logic [PAD_COUNT-1:0] r_pad_status, n_pad_status;
    logic                 r_flash_all, n_flash_all;
    logic [5:0]           r_cnt, n_cnt;
    logic [COL_W-1:0]     r_col, n_col;
    logic [PAD_IDX_W-1:0] r_note, n_note;
    logic                 r_final, n_final;

    logic                 r_out_valid, n_out_valid;
    logic [PAD_IDX_W-1:0] r_out_index, n_out_index;
    logic                 r_out_lit, n_out_lit;
    logic                 r_out_fu, n_out_fu;
    logic                 r_out_fl, n_out_fl;
    logic                 r_out_last, n_out_last;

    logic [7:0]           note_b;
    logic [PAD_IDX_W-1:0] note_idx;
    logic                 in_border;
    logic                 cur_lit;
    logic [ROW_W-1:0]     row;
    logic                 row_done;
    logic [GRID_HEIGHT-1:0] col_bits;
    logic                 later_lit;
    logic [PAD_IDX_W-1:0] col_idx;

    assign note_b    = {1'b0, i_op.note};
    assign note_idx  = i_op.note[PAD_IDX_W-1:0];
    assign in_border = note_b < (r_flash_all ? PAD_END_B : FLASH_END_B);
    assign cur_lit   = r_pad_status[note_idx];
    assign row       = r_cnt[ROW_W-1:0];
    assign row_done  = (row == ROW_W'(GRID_HEIGHT - 1));
    assign col_idx   = PAD_IDX_W'(row * GRID_WIDTH) + PAD_IDX_W'(r_col);

    // lit bits of the current column, one per row, and any lit row past the walk
    always_comb begin
        later_lit = 1'b0;
        for (int rr = 0; rr < GRID_HEIGHT; rr++) begin
            col_bits[rr] = r_pad_status[PAD_IDX_W'(rr * GRID_WIDTH) + PAD_IDX_W'(r_col)];
            if (col_bits[rr] && (rr > int'(row))) begin
                later_lit = 1'b1;
            end
        end
    end

    assign o_pop = (r_state == BK_IDLE) && !i_q_status.empty;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    case (i_op.kind)
                        OP_TOGGLE: n_state = BK_SWEEP;
                        OP_PRESS:  n_state = in_border ? BK_IDLE : BK_COLUMN;
                        default:   n_state = BK_IDLE;
                    endcase
                end
            end
            BK_SWEEP: begin
                if (r_cnt == 6'(PAD_COUNT - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_COLUMN: begin
                if (row_done) begin
                    n_state = r_final ? BK_FINAL : BK_IDLE;
                end
            end
            BK_FINAL: n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // datapath and messages
    always_comb begin
        n_pad_status = r_pad_status;
        n_flash_all  = r_flash_all;
        n_cnt        = r_cnt;
        n_col        = r_col;
        n_note       = r_note;
        n_final      = r_final;
        n_out_valid  = 1'b0;
        n_out_index  = r_out_index;
        n_out_lit    = 1'b0;
        n_out_fu     = 1'b0;
        n_out_fl     = 1'b0;
        n_out_last   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_cnt  = 6'd0;
                    n_note = note_idx;
                    n_col  = COL_TAB[i_op.note];
                    case (i_op.kind)
                        OP_TOGGLE: begin
                            n_flash_all = !r_flash_all;
                        end
                        OP_RELEASE: begin
                            if (in_border && cur_lit) begin
                                n_pad_status[note_idx] = 1'b0;
                                n_out_valid = 1'b1;
                                n_out_index = note_idx;
                                n_out_last  = 1'b1;
                            end
                        end
                        OP_PRESS: begin
                            if (in_border) begin
                                if (!cur_lit) begin
                                    n_pad_status[note_idx] = 1'b1;
                                    n_out_valid = 1'b1;
                                    n_out_index = note_idx;
                                    n_out_lit   = 1'b1;
                                    n_out_last  = 1'b1;
                                end
                            end else begin
                                // latch pad lights last unless it was lit; stop button never
                                n_final = (note_b < PAD_END_B) && !cur_lit;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_SWEEP: begin
                n_pad_status[r_cnt[PAD_IDX_W-1:0]] = 1'b0;
                n_out_valid = 1'b1;
                n_out_index = r_cnt[PAD_IDX_W-1:0];
                n_out_fu    = (r_cnt == 6'd0);
                n_out_fl    = (r_cnt == 6'd0) && r_flash_all;
                n_out_last  = (r_cnt == 6'(PAD_COUNT - 1));
                n_cnt       = 6'(r_cnt + 6'd1);
            end
            BK_COLUMN: begin
                if (col_bits[row]) begin
                    n_pad_status[col_idx] = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_index = col_idx;
                    n_out_last  = !later_lit && !r_final;
                end
                n_cnt = 6'(r_cnt + 6'd1);
            end
            BK_FINAL: begin
                n_pad_status[r_note] = 1'b1;
                n_out_valid = 1'b1;
                n_out_index = r_note;
                n_out_lit   = 1'b1;
                n_out_last  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_pad_status <= '0;
            r_flash_all  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pad_status <= n_pad_status;
            r_flash_all  <= n_flash_all;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_col       <= n_col;
        r_note      <= n_note;
        r_final     <= n_final;
        r_out_index <= n_out_index;
        r_out_lit   <= n_out_lit;
        r_out_fu    <= n_out_fu;
        r_out_fl    <= n_out_fl;
        r_out_last  <= n_out_last;
    end

    assign o_strobe       = r_out_valid;
    assign o_pad_index    = r_out_index;
    assign o_pad_lit      = r_out_lit;
    assign o_flash_update = r_out_fu;
    assign o_flash_lit    = r_out_fl;
    assign o_last         = r_out_last;

`ifndef NO_ASSERTIONS
    a_sweep_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SWEEP) |=> r_out_valid)
        else $error("sweep step without LED message");

    a_final_lights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_FINAL) |=> (r_out_valid && r_out_lit && r_out_last))
        else $error("latch pad message missing or not last");

    a_flash_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fu) |-> (r_out_index == '0 && !r_out_lit))
        else $error("flash indicator update off the first sweep message");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> !o_pop)
        else $error("op taken while back end busy");
`endif

endmodule

`default_nettype wire

// ===== design/pad_grid_latch_controller_unit.sv =====
// Top level of the pad grid latch controller: front end, op queue and back end.
`default_nettype none

// Pad grid latch controller. Note events (start/busy command transfer) are
// filtered by the listen channel and classified in the cycle they are taken,
// then wait in a two-deep op queue; busy is high only while that queue is full.
// The back end pops one op and produces LED messages, one per cycle at most,
// each shown for exactly one cycle with o_strobe; the receiver cannot stall,
// so messages flow at the back end's pace. With the back end free, an event's op
// passes the queue register and the back end's output register before its first
// message; a column walk or a sweep enters its own state after the idle state.
// Back end work per event:
//   - momentary pad press or release: idle state only, at most one message;
//   - latch pad or stop button: the idle state takes the op, then a walk down
//     the column, one step per grid row (GRID_HEIGHT), then the final state
//     lighting the latch pad if it was not lit (never for the stop button);
//   - flash-all toggle: the idle state takes the op, then a sweep of all
//     PAD_COUNT pads, one message a cycle;
//   - filtered events: no back end time.
// The column walk and the toggle sweep set the sustained rate. o_last marks the
// final message of each event. Pad state lives in flip-flops cleared at reset.
// The user writes the listen channel register on its own channel only while the
// block is idle; the block does not enforce this (o_cfg_ready is always high).

module pad_grid_latch_controller_unit import pgl_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [3:0]           i_cfg_data,
    // event command
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [3:0]           i_channel,
    input  wire logic [6:0]           i_note,
    input  wire logic [6:0]           i_velocity,
    // LED messages
    output logic                      o_strobe,
    output logic [PAD_IDX_W-1:0]      o_pad_index,
    output logic                      o_pad_lit,
    output logic                      o_flash_update,
    output logic                      o_flash_lit,
    output logic                      o_last
);

    logic      push;
    logic      pop;
    t_op       front_op;
    t_op       queue_op;
    t_q_status q_status;

    assign busy = q_status.full;

    pgl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .i_busy      (q_status.full),
        .i_cmd       (i_cmd),
        .i_channel   (i_channel),
        .i_note      (i_note),
        .i_velocity  (i_velocity),
        .o_push      (push),
        .o_op        (front_op)
    );

    pgl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (front_op),
        .i_pop    (pop),
        .o_op     (queue_op),
        .o_status (q_status)
    );

    pgl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_op           (queue_op),
        .o_pop          (pop),
        .o_strobe       (o_strobe),
        .o_pad_index    (o_pad_index),
        .o_pad_lit      (o_pad_lit),
        .o_flash_update (o_flash_update),
        .o_flash_lit    (o_flash_lit),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
